/* src/fsc_pkg.sv */
// fsc_pkg: shared types, constants and plane tables for the frustum sphere cull unit
// no dependencies; used by the channel interfaces and every module of the block

package fsc_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int NUM_PLANES  = 6;
   localparam int DATA_W      = 32;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int ACC_W       = PROD_W + 2;
   localparam int DIV_W       = DATA_W + FRAC_BITS;
   localparam int MAT_DEPTH   = 16;
   localparam int MAT_AW      = $clog2(MAT_DEPTH);
   localparam int PLANE_DEPTH = NUM_PLANES * 4;
   localparam int PLANE_AW    = $clog2(PLANE_DEPTH);

   typedef enum logic [1:0] {
      KIND_LOAD_PROJ = 2'd0,
      KIND_LOAD_MV   = 2'd1,
      KIND_RECOMPUTE = 2'd2,
      KIND_QUERY     = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QRY_ISSUE,
      ST_QRY_DRAIN,
      ST_QRY_OUT,
      ST_CLIP_ISSUE,
      ST_CLIP_DRAIN,
      ST_PL_BASE,
      ST_PL_TERM,
      ST_PL_COMP,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_DIV_GO,
      ST_DIV_WAIT
   } state_type;

   // clip column combined with column 3 for each plane
   function automatic logic [1:0] plane_row(input logic [2:0] p);
      logic [1:0] r;
      unique case (p)
         3'd0, 3'd1: r = 2'd0;
         3'd2, 3'd3: r = 2'd1;
         default:    r = 2'd2;
      endcase
      return r;
   endfunction

   // 1 adds the column, 0 subtracts it
   function automatic logic plane_add(input logic [2:0] p);
      logic a;
      unique case (p)
         3'd0, 3'd3, 3'd4: a = 1'b1;
         default:          a = 1'b0;
      endcase
      return a;
   endfunction

endpackage

/* src/fsc_if.sv */
// fsc_if: request and response channel interfaces of the frustum sphere cull unit
// depends on fsc_pkg for field widths

interface fsc_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          kind;
   logic [3:0]                          elem_index;
   logic signed [fsc_pkg::DATA_W-1:0]   elem_value;
   logic signed [fsc_pkg::DATA_W-1:0]   centre_x;
   logic signed [fsc_pkg::DATA_W-1:0]   centre_y;
   logic signed [fsc_pkg::DATA_W-1:0]   centre_z;
   logic [fsc_pkg::DATA_W-2:0]          radius;

   modport source (output valid, kind, elem_index, elem_value, centre_x, centre_y,
                   centre_z, radius, input ready);
   modport sink   (input valid, kind, elem_index, elem_value, centre_x, centre_y,
                   centre_z, radius, output ready);
endinterface

interface fsc_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, inside_res, input ready);
   modport sink   (input valid, inside_res, output ready);
endinterface

/* src/frustum_sphere_cull_unit.sv */
// frustum_sphere_cull_unit: top level of the frustum plane extraction and sphere cull block
// depends on fsc_pkg, fsc_req_if, fsc_rsp_if, fsc_root and fsc_divider

// One request at a time. A sphere query streams the 24 plane coefficients out of the plane
// memory, one per cycle, through one shared 32x32 multiplier and an accumulator, and its
// result goes to the response register. A recompute runs 64 multiply-accumulates for the clip
// matrix, then per plane reads the clip memory, squares three components, takes a 32-step
// square root and divides each of four components with a bit-serial divider of 32+FRAC_BITS
// steps, or keeps the raw plane when the length is zero. Until the first recompute finishes
// the planes read as zero. The response register lets the next request enter while a result
// waits to be taken.

module frustum_sphere_cull_unit (
   input  logic       clock,
   input  logic       reset,
   fsc_req_if.sink    req_ch,
   fsc_rsp_if.source  rsp_ch
);

   localparam int DW = fsc_pkg::DATA_W;
   localparam int FB = fsc_pkg::FRAC_BITS;
   localparam logic signed [DW-1:0] ONE_FX = DW'(1) <<< FB;
   localparam logic signed [fsc_pkg::ACC_W-1:0] SAT_MAX = fsc_pkg::ACC_W'(32'sh7FFF_FFFF);
   localparam logic signed [fsc_pkg::ACC_W-1:0] SAT_MIN = -(fsc_pkg::ACC_W'(64'h8000_0000));
   localparam logic [fsc_pkg::DIV_W-1:0] Q_LIM = fsc_pkg::DIV_W'(64'h8000_0000);

   function automatic logic signed [DW-1:0] sat_acc(input logic signed [fsc_pkg::ACC_W-1:0] v);
      logic signed [DW-1:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[DW-1:0];
      end
      return r;
   endfunction

   fsc_pkg::state_type state_ff, state_in;

   logic [5:0]                          cnt_ff, cnt_in;
   logic                                v1_ff, v1_in, v2_ff;
   logic [5:0]                          t1_ff, t2_ff;
   logic signed [fsc_pkg::PROD_W-1:0]   prod_ff;
   logic signed [DW-1:0]                mul_a, mul_b;
   logic signed [fsc_pkg::ACC_W-1:0]    acc_ff, acc_in, acc_add, acc_sum;
   logic signed [fsc_pkg::PROD_W-1:0]   prod_shift;
   logic                                clip_phase;
   logic                                outside_ff, outside_in;
   logic signed [DW-1:0]                cx_ff, cy_ff, cz_ff;
   logic signed [fsc_pkg::ACC_W-1:0]    lim_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_inside_ff, rsp_inside_in;
   logic [2:0]                          p_ff, p_in;
   logic [1:0]                          k_ff, k_in;
   logic signed [DW-1:0]                base_ff, base_in;
   logic signed [DW-1:0]                comp_ff [4];
   logic                                comp_we;
   logic signed [DW-1:0]                comp_val;
   logic signed [DW:0]                  comp_wide;
   logic [fsc_pkg::PROD_W-1:0]          sq_ff, sq_in;
   logic [DW-1:0]                       len_ff, len_in;
   logic                                planes_ok_ff, planes_ok_in;
   logic                                adv;
   logic                                req_fire;

   logic signed [DW-1:0]                proj_mem  [fsc_pkg::MAT_DEPTH];
   logic signed [DW-1:0]                mv_mem    [fsc_pkg::MAT_DEPTH];
   logic signed [DW-1:0]                clip_mem  [fsc_pkg::MAT_DEPTH];
   logic signed [DW-1:0]                plane_mem [fsc_pkg::PLANE_DEPTH];
   logic signed [DW-1:0]                proj_rd_ff, mv_rd_ff, clip_rd_ff, plane_rd_ff;
   logic signed [DW-1:0]                plane_rd;
   logic                                proj_we, mv_we, clip_we, plane_we;
   logic [fsc_pkg::MAT_AW-1:0]          proj_raddr, mv_raddr, clip_raddr, clip_waddr;
   logic signed [DW-1:0]                clip_wdata, plane_wdata;
   logic [fsc_pkg::PLANE_AW-1:0]        plane_waddr;

   logic                                root_start, root_done;
   logic [DW-1:0]                       root_len;
   logic                                div_start, div_done;
   logic [fsc_pkg::DIV_W-1:0]           div_quot;
   logic [DW-1:0]                       comp_mag;
   logic [DW-1:0]                       q_clip;
   logic signed [DW-1:0]                div_res;

   fsc_root u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sq_ff),
      .done     (root_done),
      .root     (root_len)
   );

   fsc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({comp_mag, {FB{1'b0}}}),
      .divisor  (len_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_fire = req_ch.valid && req_ch.ready;

   // clip element = saturated sum of four products, each rounded toward minus infinity
   assign clip_phase = (state_ff == fsc_pkg::ST_CLIP_ISSUE) ||
                       (state_ff == fsc_pkg::ST_CLIP_DRAIN);
   assign prod_shift = prod_ff >>> FB;
   assign acc_add    = clip_phase ? {{2{prod_shift[fsc_pkg::PROD_W-1]}}, prod_shift}
                                  : {{2{prod_ff[fsc_pkg::PROD_W-1]}}, prod_ff};
   assign acc_sum    = ((t2_ff[1:0] == 2'd0) ? '0 : acc_ff) + acc_add;

   assign plane_rd   = planes_ok_ff ? plane_rd_ff : '0;
   assign proj_raddr = {cnt_ff[1:0], cnt_ff[3:2]};
   assign mv_raddr   = {cnt_ff[5:4], cnt_ff[1:0]};

   assign comp_wide  = fsc_pkg::plane_add(p_ff)
                       ? ({base_ff[DW-1], base_ff} + {clip_rd_ff[DW-1], clip_rd_ff})
                       : ({base_ff[DW-1], base_ff} - {clip_rd_ff[DW-1], clip_rd_ff});
   assign comp_val   = (comp_wide[DW] != comp_wide[DW-1])
                       ? (comp_wide[DW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                       : comp_wide[DW-1:0];

   assign comp_mag   = comp_ff[k_ff][DW-1] ? DW'(-comp_ff[k_ff]) : DW'(comp_ff[k_ff]);
   assign q_clip     = (div_quot > Q_LIM) ? 32'h8000_0000 : div_quot[DW-1:0];
   assign div_res    = comp_ff[k_ff][DW-1] ? -$signed(q_clip)
                       : (q_clip[DW-1] ? 32'sh7FFF_FFFF : $signed(q_clip));

   function automatic logic [2:0] plane_last();
      return 3'(fsc_pkg::NUM_PLANES - 1);
   endfunction

   function automatic logic [1:0] plane_row(input logic [2:0] p);
      return fsc_pkg::plane_row(p);
   endfunction

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      v1_in         = 1'b0;
      acc_in        = acc_ff;
      outside_in    = outside_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_inside_in = rsp_inside_ff;
      p_in          = p_ff;
      k_in          = k_ff;
      base_in       = base_ff;
      comp_we       = 1'b0;
      sq_in         = sq_ff;
      len_in        = len_ff;
      planes_ok_in  = planes_ok_ff;
      adv           = 1'b0;
      req_ch.ready  = 1'b0;
      proj_we       = 1'b0;
      mv_we         = 1'b0;
      clip_we       = 1'b0;
      clip_waddr    = {t2_ff[5:4], t2_ff[3:2]};
      clip_wdata    = sat_acc(acc_sum);
      clip_raddr    = '0;
      plane_we      = 1'b0;
      plane_waddr   = fsc_pkg::PLANE_AW'({p_ff, k_ff});
      plane_wdata   = comp_ff[k_ff];
      root_start    = 1'b0;
      div_start     = 1'b0;
      mul_a         = mv_rd_ff;
      mul_b         = proj_rd_ff;

      // accumulate stage of the multiply pipeline
      if (v2_ff) begin
         acc_in = acc_sum;
         if (t2_ff[1:0] == 2'd3) begin
            if (clip_phase) begin
               clip_we = 1'b1;
            end else if (acc_sum <= lim_ff) begin
               outside_in = 1'b1;
            end
         end
      end

      if (!clip_phase) begin
         mul_a = plane_rd;
         unique case (t1_ff[1:0])
            2'd0:    mul_b = cx_ff;
            2'd1:    mul_b = cy_ff;
            2'd2:    mul_b = cz_ff;
            default: mul_b = ONE_FX;
         endcase
      end

      unique case (state_ff)
         fsc_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               unique case (fsc_pkg::kind_type'(req_ch.kind))
                  fsc_pkg::KIND_LOAD_PROJ: proj_we = 1'b1;
                  fsc_pkg::KIND_LOAD_MV:   mv_we = 1'b1;
                  fsc_pkg::KIND_RECOMPUTE: begin
                     cnt_in   = '0;
                     state_in = fsc_pkg::ST_CLIP_ISSUE;
                  end
                  default: begin
                     cnt_in     = '0;
                     outside_in = 1'b0;
                     state_in   = fsc_pkg::ST_QRY_ISSUE;
                  end
               endcase
            end
         end
         fsc_pkg::ST_QRY_ISSUE: begin
            v1_in = 1'b1;
            if (cnt_ff == 6'(fsc_pkg::PLANE_DEPTH - 1)) begin
               state_in = fsc_pkg::ST_QRY_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         fsc_pkg::ST_QRY_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = fsc_pkg::ST_QRY_OUT;
            end
         end
         fsc_pkg::ST_QRY_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = !outside_ff;
               state_in      = fsc_pkg::ST_IDLE;
            end
         end
         fsc_pkg::ST_CLIP_ISSUE: begin
            v1_in = 1'b1;
            if (cnt_ff == 6'd63) begin
               state_in = fsc_pkg::ST_CLIP_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         fsc_pkg::ST_CLIP_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               p_in     = '0;
               k_in     = '0;
               state_in = fsc_pkg::ST_PL_BASE;
            end
         end
         fsc_pkg::ST_PL_BASE: begin
            clip_raddr = {k_ff, 2'd3};
            state_in   = fsc_pkg::ST_PL_TERM;
         end
         fsc_pkg::ST_PL_TERM: begin
            clip_raddr = {k_ff, plane_row(p_ff)};
            base_in    = clip_rd_ff;
            state_in   = fsc_pkg::ST_PL_COMP;
         end
         fsc_pkg::ST_PL_COMP: begin
            comp_we = 1'b1;
            if (k_ff == 2'd3) begin
               k_in     = '0;
               state_in = fsc_pkg::ST_SQ_MUL;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = fsc_pkg::ST_PL_BASE;
            end
         end
         fsc_pkg::ST_SQ_MUL: begin
            mul_a    = comp_ff[k_ff];
            mul_b    = comp_ff[k_ff];
            state_in = fsc_pkg::ST_SQ_ACC;
         end
         fsc_pkg::ST_SQ_ACC: begin
            sq_in = ((k_ff == 2'd0) ? '0 : sq_ff) + prod_ff;
            if (k_ff == 2'd2) begin
               k_in     = '0;
               state_in = fsc_pkg::ST_ROOT_GO;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = fsc_pkg::ST_SQ_MUL;
            end
         end
         fsc_pkg::ST_ROOT_GO: begin
            root_start = 1'b1;
            state_in   = fsc_pkg::ST_ROOT_WAIT;
         end
         fsc_pkg::ST_ROOT_WAIT: begin
            if (root_done) begin
               len_in   = root_len;
               state_in = fsc_pkg::ST_DIV_GO;
            end
         end
         fsc_pkg::ST_DIV_GO: begin
            // zero-length normal keeps the raw plane
            if (len_ff == '0) begin
               plane_we = 1'b1;
               adv      = 1'b1;
            end else begin
               div_start = 1'b1;
               state_in  = fsc_pkg::ST_DIV_WAIT;
            end
         end
         fsc_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               plane_we    = 1'b1;
               plane_wdata = div_res;
               adv         = 1'b1;
            end
         end
         default: state_in = fsc_pkg::ST_IDLE;
      endcase

      if (adv) begin
         if (k_ff == 2'd3) begin
            k_in = '0;
            if (p_ff == plane_last()) begin
               planes_ok_in = 1'b1;
               state_in     = fsc_pkg::ST_IDLE;
            end else begin
               p_in     = p_ff + 1'b1;
               state_in = fsc_pkg::ST_PL_BASE;
            end
         end else begin
            k_in     = k_ff + 1'b1;
            state_in = fsc_pkg::ST_DIV_GO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fsc_pkg::ST_IDLE;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         planes_ok_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         v1_ff         <= v1_in;
         v2_ff         <= v1_ff;
         rsp_valid_ff  <= rsp_valid_in;
         planes_ok_ff  <= planes_ok_in;
      end
      cnt_ff        <= cnt_in;
      t1_ff         <= cnt_ff;
      t2_ff         <= t1_ff;
      prod_ff       <= mul_a * mul_b;
      acc_ff        <= acc_in;
      outside_ff    <= outside_in;
      rsp_inside_ff <= rsp_inside_in;
      p_ff          <= p_in;
      k_ff          <= k_in;
      base_ff       <= base_in;
      sq_ff         <= sq_in;
      len_ff        <= len_in;
      if (comp_we) begin
         comp_ff[k_ff] <= comp_val;
      end
      if (req_fire && (fsc_pkg::kind_type'(req_ch.kind) == fsc_pkg::KIND_QUERY)) begin
         cx_ff  <= req_ch.centre_x;
         cy_ff  <= req_ch.centre_y;
         cz_ff  <= req_ch.centre_z;
         lim_ff <= -$signed({{(fsc_pkg::ACC_W - DW + 1 - FB){1'b0}}, req_ch.radius,
                             {FB{1'b0}}});
      end
   end

   // matrix, clip and plane memories
   always_ff @(posedge clock) begin
      if (proj_we) begin
         proj_mem[req_ch.elem_index] <= req_ch.elem_value;
      end
      proj_rd_ff <= proj_mem[proj_raddr];
   end

   always_ff @(posedge clock) begin
      if (mv_we) begin
         mv_mem[req_ch.elem_index] <= req_ch.elem_value;
      end
      mv_rd_ff <= mv_mem[mv_raddr];
   end

   always_ff @(posedge clock) begin
      if (clip_we) begin
         clip_mem[clip_waddr] <= clip_wdata;
      end
      clip_rd_ff <= clip_mem[clip_raddr];
   end

   always_ff @(posedge clock) begin
      if (plane_we) begin
         plane_mem[plane_waddr] <= plane_wdata;
      end
      plane_rd_ff <= plane_mem[cnt_ff[fsc_pkg::PLANE_AW-1:0]];
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.inside_res = rsp_inside_ff;

   // a new request never finds work left in the multiply pipeline
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (!v1_ff && !v2_ff))
      else $error("request accepted while multiply pipeline busy");

   // a response only appears out of the query output step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == fsc_pkg::ST_QRY_OUT))
      else $error("response raised outside query output");

   // plane writes stay inside the plane memory
   a_plane_addr: assert property (@(posedge clock) disable iff (reset)
      plane_we |-> (p_ff <= plane_last()))
      else $error("plane write beyond last plane");

   // divider and root never start together, and the divider never starts with a zero length
   a_unit_excl: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !root_start && (len_ff != '0))
      else $error("divider started with zero length");

endmodule

/* src/fsc_root.sv */
// fsc_root: iterative integer square root, one result bit per cycle
// depends on fsc_pkg for widths

module fsc_root (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fsc_pkg::PROD_W-1:0]      radicand,
   output logic                            done,
   output logic [fsc_pkg::DATA_W-1:0]      root
);

   localparam int STEP_W = $clog2(fsc_pkg::PROD_W / 2);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic [fsc_pkg::PROD_W-1:0]   rem_ff, rem_in;
   logic [fsc_pkg::PROD_W-1:0]   res_ff, res_in;
   logic [fsc_pkg::PROD_W-1:0]   bit_val;
   logic [fsc_pkg::PROD_W-1:0]   trial;

   // bit weight 4^step
   assign bit_val = {{(fsc_pkg::PROD_W-1){1'b0}}, 1'b1} << {step_ff, 1'b0};
   assign trial   = res_ff + bit_val;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(fsc_pkg::PROD_W / 2 - 1);
         rem_in  = radicand;
         res_in  = '0;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_val;
         end else begin
            res_in = res_ff >> 1;
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
   end

   assign done = done_ff;
   assign root = res_ff[fsc_pkg::DATA_W-1:0];

endmodule

/* src/fsc_divider.sv */
// fsc_divider: restoring unsigned divider, one quotient bit per cycle
// depends on fsc_pkg for widths

module fsc_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fsc_pkg::DIV_W-1:0]       dividend,
   input  logic [fsc_pkg::DATA_W-1:0]      divisor,
   output logic                            done,
   output logic [fsc_pkg::DIV_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(fsc_pkg::DIV_W);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [fsc_pkg::DATA_W-1:0]    rem_ff, rem_in;
   logic [fsc_pkg::DIV_W-1:0]     quot_ff, quot_in;
   logic [fsc_pkg::DATA_W-1:0]    den_ff, den_in;
   logic [fsc_pkg::DATA_W:0]      shifted;
   logic [fsc_pkg::DATA_W:0]      diff;

   assign shifted = {rem_ff, quot_ff[fsc_pkg::DIV_W-1]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(fsc_pkg::DIV_W - 1);
         rem_in  = '0;
         quot_in = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[fsc_pkg::DATA_W]) begin
            rem_in  = diff[fsc_pkg::DATA_W-1:0];
            quot_in = {quot_ff[fsc_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[fsc_pkg::DATA_W-1:0];
            quot_in = {quot_ff[fsc_pkg::DIV_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule
